// ===== design/periodic_timer_scheduler_defines.svh =====
// Assertion helpers for the timer scheduler sequencer
`ifndef PERIODIC_TIMER_SCHEDULER_DEFINES_SVH
`define PERIODIC_TIMER_SCHEDULER_DEFINES_SVH

// Check that a condition implies a consequence on every clock edge out of reset
`define PTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer scheduler implication check failed");

// Check that a condition never holds on a clock edge out of reset
`define PTS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("timer scheduler forbidden condition seen");

`endif

// ===== design/ptsch_pkg.sv =====
package ptsch_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int RATE_W         = 24;
    localparam int ID_W           = 4;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [RATE_W-1:0] t_rate;

    localparam t_time TIME_MAX = '1;

    // Command codes; code 7 is unused and only acknowledged
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_RATE   = 3'd2,
        CMD_BOOST  = 3'd3,
        CMD_TRIG   = 3'd4,
        CMD_SCAN   = 3'd5,
        CMD_QUERY  = 3'd6
    } t_cmd;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Memory port controls from the sequencer
    typedef struct packed {
        logic re;
        logic we_trig;
        logic we_rate;
    } t_mem_ctl;

    // Saturating add of a rate to a time
    function automatic t_time sat_add(input t_time a, input t_rate b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W+1-RATE_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ===== design/ptsch_ram.sv =====
module ptsch_ram #(
    parameter int WIDTH = ptsch_pkg::TIME_W,
    parameter int DEPTH = ptsch_pkg::NUM_TIMERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptsch_seq.sv =====
`include "periodic_timer_scheduler_defines.svh"

module ptsch_seq #(
    parameter int NUM_TIMERS = ptsch_pkg::NUM_TIMERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enabled,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_cmd,
    input  logic [ptsch_pkg::ID_W-1:0]    i_timer_id,
    input  ptsch_pkg::t_rate              i_value,
    input  ptsch_pkg::t_time              i_now,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [ptsch_pkg::ID_W-1:0]    o_slot,
    output logic                          o_ok,
    output logic                          o_active,
    output ptsch_pkg::t_time              o_wait_ticks,
    output logic                          o_none_pending,
    output logic                          o_last,
    // memory ports
    output ptsch_pkg::t_mem_ctl           o_mem,
    output logic [$clog2(NUM_TIMERS)-1:0] o_raddr,
    output logic [$clog2(NUM_TIMERS)-1:0] o_waddr,
    output ptsch_pkg::t_time              o_wtrig,
    output ptsch_pkg::t_rate              o_wrate,
    input  ptsch_pkg::t_time              i_rtrig,
    input  ptsch_pkg::t_rate              i_rrate
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_CHECK = 5'b00100,
        S_SWEEP = 5'b01000,
        S_END   = 5'b10000
    } t_state;

    // control state
    t_state                  r_state, n_state;
    logic [NUM_TIMERS-1:0]   r_active, n_active;
    logic                    r_force, n_force;
    logic [IW-1:0]           r_es, n_es;
    logic                    r_ev, n_ev;
    logic                    r_out_valid, n_out_valid;
    logic [IW-1:0]           r_idx, n_idx;
    logic                    r_min_valid, n_min_valid;

    // payload state
    ptsch_pkg::t_cmd         r_cmd, n_cmd;
    logic [ptsch_pkg::ID_W-1:0] r_id, n_id;
    ptsch_pkg::t_rate        r_val, n_val;
    ptsch_pkg::t_time        r_now, n_now;
    logic [IW-1:0]           r_min_slot, n_min_slot;
    ptsch_pkg::t_time        r_min_time, n_min_time;
    ptsch_pkg::t_kind        r_kind, n_kind;
    logic [ptsch_pkg::ID_W-1:0] r_slot, n_slot;
    logic                    r_ok, n_ok;
    logic                    r_act, n_act;
    ptsch_pkg::t_time        r_wait, n_wait;
    logic                    r_none, n_none;
    logic                    r_last, n_last;

    logic                    in_acc;
    logic                    out_free;
    logic                    out_load;
    logic [IW-1:0]           id_addr;
    logic                    id_in_range;
    logic                    cur_active;
    logic                    fire;
    logic                    better;
    ptsch_pkg::t_time        sum_trig;
    ptsch_pkg::t_time        new_trig;
    ptsch_pkg::t_time        cand;
    logic                    mem_clash;
    logic                    fire_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign id_addr     = IW'(r_id);
    assign id_in_range = int'(r_id) < NUM_TIMERS;
    assign cur_active  = id_in_range ? r_active[id_addr] : 1'b0;

    // Sweep datapath: reschedule a due slot and track the earliest trigger
    assign fire     = r_active[r_idx] && (i_rtrig <= r_now);
    assign sum_trig = ptsch_pkg::sat_add(i_rtrig, i_rrate);
    assign new_trig = (sum_trig < r_now) ? r_now : sum_trig;
    assign cand     = fire ? new_trig : i_rtrig;
    assign better   = r_active[r_idx] && (!r_min_valid || (cand < r_min_time));

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_force     = r_force;
        n_es        = r_es;
        n_ev        = r_ev;
        n_idx       = r_idx;
        n_min_valid = r_min_valid;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_val       = r_val;
        n_now       = r_now;
        n_min_slot  = r_min_slot;
        n_min_time  = r_min_time;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_ok        = r_ok;
        n_act       = r_act;
        n_wait      = r_wait;
        n_none      = r_none;
        n_last      = r_last;
        out_load    = 1'b0;
        o_mem       = '0;
        o_raddr     = '0;
        o_waddr     = id_addr;
        o_wtrig     = ptsch_pkg::sat_add(r_now, r_val);
        o_wrate     = r_val;

        unique case (r_state)
            S_IDLE: begin
                // Latch the transaction and fetch the slot it needs
                if (in_acc) begin
                    n_cmd   = ptsch_pkg::t_cmd'(i_cmd);
                    n_id    = i_timer_id;
                    n_val   = i_value;
                    n_now   = i_now;
                    o_mem.re = 1'b1;
                    if (ptsch_pkg::t_cmd'(i_cmd) == ptsch_pkg::CMD_SCAN) begin
                        o_raddr = r_es;
                        n_state = S_CHECK;
                    end else begin
                        o_raddr = IW'(i_timer_id);
                        n_state = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                // Apply the slot command and acknowledge it
                if (out_free) begin
                    out_load = 1'b1;
                    n_kind   = ptsch_pkg::KIND_ACK;
                    n_slot   = r_id;
                    n_ok     = 1'b0;
                    n_act    = cur_active;
                    n_wait   = '0;
                    n_none   = 1'b0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    if (id_in_range) begin
                        case (r_cmd)
                            ptsch_pkg::CMD_ADD: begin
                                if (!cur_active) begin
                                    n_active[id_addr] = 1'b1;
                                    o_mem.we_trig     = 1'b1;
                                    o_mem.we_rate     = 1'b1;
                                    n_force           = 1'b1;
                                    n_ok              = 1'b1;
                                end
                                n_act = 1'b1;
                            end
                            ptsch_pkg::CMD_REMOVE: begin
                                if (cur_active) begin
                                    n_active[id_addr] = 1'b0;
                                    if (r_ev && (r_es == id_addr)) begin
                                        n_ev    = 1'b0;
                                        n_force = 1'b1;
                                    end
                                    n_ok = 1'b1;
                                end
                                n_act = 1'b0;
                            end
                            ptsch_pkg::CMD_RATE: begin
                                o_mem.we_trig = 1'b1;
                                o_mem.we_rate = 1'b1;
                                n_force       = 1'b1;
                            end
                            ptsch_pkg::CMD_BOOST: begin
                                o_wtrig       = ptsch_pkg::sat_add(i_rtrig, r_val);
                                o_mem.we_trig = 1'b1;
                                n_force       = 1'b1;
                            end
                            ptsch_pkg::CMD_TRIG: begin
                                o_wtrig       = r_now;
                                o_mem.we_trig = 1'b1;
                                n_force       = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_CHECK: begin
                // Report straight away when disabled or the cached slot is not due
                if (!i_enabled) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_kind   = ptsch_pkg::KIND_END;
                        n_ok     = 1'b0;
                        n_act    = 1'b0;
                        n_last   = 1'b1;
                        n_slot   = '0;
                        n_wait   = '0;
                        n_none   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (!r_force && r_ev && (i_rtrig > r_now)) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_kind   = ptsch_pkg::KIND_END;
                        n_ok     = 1'b0;
                        n_act    = 1'b0;
                        n_last   = 1'b1;
                        n_slot   = ptsch_pkg::ID_W'(r_es);
                        n_wait   = i_rtrig - r_now;
                        n_none   = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    // Start a full sweep from slot zero
                    n_force     = 1'b0;
                    o_mem.re    = 1'b1;
                    o_raddr     = '0;
                    n_idx       = '0;
                    n_min_valid = 1'b0;
                    n_state     = S_SWEEP;
                end
            end

            S_SWEEP: begin
                // Visit one slot; hold while a fired result cannot be sent
                if (!(fire && !out_free)) begin
                    if (fire) begin
                        o_waddr       = r_idx;
                        o_wtrig       = new_trig;
                        o_mem.we_trig = 1'b1;
                        out_load      = 1'b1;
                        n_kind        = ptsch_pkg::KIND_FIRE;
                        n_slot        = ptsch_pkg::ID_W'(r_idx);
                        n_ok          = 1'b0;
                        n_act         = 1'b1;
                        n_wait        = '0;
                        n_none        = 1'b0;
                        n_last        = 1'b0;
                    end
                    if (better) begin
                        n_min_valid = 1'b1;
                        n_min_slot  = r_idx;
                        n_min_time  = cand;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_END;
                    end else begin
                        o_mem.re = 1'b1;
                        o_raddr  = r_idx + 1'b1;
                        n_idx    = r_idx + 1'b1;
                    end
                end
            end

            S_END: begin
                // Report the earliest trigger and refresh the cache
                if (out_free) begin
                    out_load = 1'b1;
                    n_kind   = ptsch_pkg::KIND_END;
                    n_ok     = 1'b0;
                    n_act    = 1'b0;
                    n_last   = 1'b1;
                    n_none   = !r_min_valid;
                    n_slot   = r_min_valid ? ptsch_pkg::ID_W'(r_min_slot) : '0;
                    n_wait   = (r_min_valid && (r_min_time > r_now)) ?
                               (r_min_time - r_now) : '0;
                    n_ev     = r_min_valid;
                    n_es     = r_min_valid ? r_min_slot : '0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register: load a new result or drop the one taken
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_force     <= 1'b1;
            r_es        <= '0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_min_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_force     <= n_force;
            r_es        <= n_es;
            r_ev        <= n_ev;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_min_valid <= n_min_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_val      <= n_val;
        r_now      <= n_now;
        r_min_slot <= n_min_slot;
        r_min_time <= n_min_time;
        r_kind     <= n_kind;
        r_slot     <= n_slot;
        r_ok       <= n_ok;
        r_act      <= n_act;
        r_wait     <= n_wait;
        r_none     <= n_none;
        r_last     <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_slot         = r_slot;
    assign o_ok           = r_ok;
    assign o_active       = r_act;
    assign o_wait_ticks   = r_wait;
    assign o_none_pending = r_none;
    assign o_last         = r_last;

    // Terms for the checks below
    assign mem_clash = o_mem.re && (o_mem.we_trig || o_mem.we_rate) && (o_raddr == o_waddr);
    assign fire_load = out_load && (n_kind == ptsch_pkg::KIND_FIRE);

    `PTS_ASSERT_NEVER(a_no_rw_same_slot, i_clk, i_rst_n, mem_clash)
    `PTS_ASSERT_IMPL(a_fire_only_in_sweep, i_clk, i_rst_n, fire_load, r_state == S_SWEEP)
    `PTS_ASSERT_IMPL(a_sweep_clears_force, i_clk, i_rst_n, r_state == S_SWEEP, !r_force)
    `PTS_ASSERT_IMPL(a_cache_slot_active, i_clk, i_rst_n, r_ev, r_active[r_es])

endmodule

// ===== design/periodic_timer_scheduler.sv =====
// Periodic timer scheduler for up to NUM_TIMERS slots (ids 0..15 addressable).
// One command is processed at a time. A slot command (add, remove, set rate,
// boost, trigger now, query) moves from acceptance to the execute state, which
// loads its acknowledge into the output register and returns to idle for the
// next command. A scan answered from the cached earliest slot, or while
// disabled, loads its result from the check state in the same way. A full scan
// walks the slot memories one slot per cycle through their single read port,
// holding while a fired result waits on a full output register; the other
// results wait on it too. Each fired slot gives one result in ascending
// slot order, and the scan ends with a result carrying the wait until the
// earliest trigger. Trigger times and rates live in two synchronous memories,
// each with one read and one write port, that are not cleared at reset.
module periodic_timer_scheduler #(
    parameter int NUM_TIMERS = ptsch_pkg::NUM_TIMERS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    // command channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_cmd,
    input  logic [ptsch_pkg::ID_W-1:0] i_timer_id,
    input  ptsch_pkg::t_rate           i_value,
    input  ptsch_pkg::t_time           i_now,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_kind,
    output logic [ptsch_pkg::ID_W-1:0] o_slot,
    output logic                       o_ok,
    output logic                       o_active,
    output ptsch_pkg::t_time           o_wait_ticks,
    output logic                       o_none_pending,
    output logic                       o_last
);

    localparam int IW = $clog2(NUM_TIMERS);

    logic                 r_enabled;
    ptsch_pkg::t_mem_ctl  mem_ctl;
    logic [IW-1:0]        raddr;
    logic [IW-1:0]        waddr;
    ptsch_pkg::t_time     wtrig;
    ptsch_pkg::t_rate     wrate;
    ptsch_pkg::t_time     rtrig;
    ptsch_pkg::t_rate     rrate;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    ptsch_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enabled      (r_enabled),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_timer_id     (i_timer_id),
        .i_value        (i_value),
        .i_now          (i_now),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_ok           (o_ok),
        .o_active       (o_active),
        .o_wait_ticks   (o_wait_ticks),
        .o_none_pending (o_none_pending),
        .o_last         (o_last),
        .o_mem          (mem_ctl),
        .o_raddr        (raddr),
        .o_waddr        (waddr),
        .o_wtrig        (wtrig),
        .o_wrate        (wrate),
        .i_rtrig        (rtrig),
        .i_rrate        (rrate)
    );

    // Next trigger time per slot
    ptsch_ram #(
        .WIDTH (ptsch_pkg::TIME_W),
        .DEPTH (NUM_TIMERS)
    ) u_trig_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.we_trig),
        .i_waddr (waddr),
        .i_wdata (wtrig),
        .i_re    (mem_ctl.re),
        .i_raddr (raddr),
        .o_rdata (rtrig)
    );

    // Rate per slot
    ptsch_ram #(
        .WIDTH (ptsch_pkg::RATE_W),
        .DEPTH (NUM_TIMERS)
    ) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.we_rate),
        .i_waddr (waddr),
        .i_wdata (wrate),
        .i_re    (mem_ctl.re),
        .i_raddr (raddr),
        .o_rdata (rrate)
    );

endmodule
